// File: hw/rtl/stack_gadget_rop_scorer_assert.svh
// ----------------------------------------------------------------------------
// Stack gadget ROP scorer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_GADGET_ROP_SCORER_ASSERT_SVH
`define STACK_GADGET_ROP_SCORER_ASSERT_SVH

// Checked only while out of reset
`define SGR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define SGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// Stack gadget ROP scorer package
// Shared widths, register indexes and the types passed between units.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int PID_W   = 22;
  localparam int ADDR_W  = 64;
  localparam int TIME_W  = 64;
  localparam int CONF_W  = 7;
  localparam int LEN_W   = 16;
  localparam int TOT_W   = 32;
  // pair counts of one snapshot, enough for the largest frame window
  localparam int CNT_W   = 6;
  // LRU rank, enough for the largest way count
  localparam int AGE_W   = 4;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_LEN   = 2'd1;
  localparam logic [1:0] REG_MAX_DELTA = 2'd2;

  localparam logic [CONF_W-1:0] THRESHOLD_RST = 7'd70;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST   = 16'd5;
  localparam logic [LEN_W-1:0]  MAX_DELTA_RST = 16'd4096;

  localparam logic [TOT_W-1:0]  TOT_MAX = 32'hFFFF_FFFF;

  // finished snapshot handed from front to back
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] tstamp;
    logic [ADDR_W-1:0] first_addr;
    logic [CNT_W-1:0]  shorts;
    logic [CNT_W-1:0]  normals;
  } job_t;

  // one way of a table set
  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [PID_W-1:0]  tag;
    logic [TOT_W-1:0]  s_tot;
    logic [TOT_W-1:0]  n_tot;
    logic [TIME_W-1:0] last_time;
    logic [CONF_W-1:0] conf;
    logic              alerted;
  } way_t;

endpackage

// File: hw/rtl/sgr_front.sv
// ----------------------------------------------------------------------------
// Snapshot front end
// Accepts frames, classifies adjacent pairs and emits one job per snapshot that has short pairs.
// ----------------------------------------------------------------------------
module sgr_front import sgr_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PID_W-1:0]  in_process_id,
  input  logic [ADDR_W-1:0] in_frame_address,
  input  logic              in_last_frame,
  input  logic [TIME_W-1:0] in_time_now,
  input  logic [LEN_W-1:0]  min_len,
  input  logic [LEN_W-1:0]  max_delta,
  input  logic              hold,
  output logic              push,
  output job_t              job
);

  localparam int POS_W = $clog2(MAX_FRAMES + 1);

  logic [ADDR_W-1:0] prev_r, prev_nxt, first_r, first_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  short_r, short_nxt, norm_r, norm_nxt;

  logic              accept, in_window, pair_ok, is_short, is_norm;
  logic [ADDR_W-1:0] diff;
  logic [CNT_W-1:0]  short_sum, norm_sum;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // pair classification
  assign in_window = pos_r < POS_W'(MAX_FRAMES);
  assign pair_ok   = in_window && (pos_r != '0) && (prev_r != '0) && (in_frame_address != '0);
  assign diff      = (prev_r > in_frame_address) ? prev_r - in_frame_address
                                                 : in_frame_address - prev_r;
  assign is_short  = pair_ok && (diff != '0) && (diff < ADDR_W'(min_len));
  assign is_norm   = pair_ok && (diff >= ADDR_W'(min_len)) && (diff < ADDR_W'(max_delta));
  assign short_sum = short_r + CNT_W'(is_short);
  assign norm_sum  = norm_r + CNT_W'(is_norm);

  // job out at end of a snapshot with short pairs
  assign push           = accept && in_last_frame && (short_sum != '0);
  assign job.pid        = in_process_id;
  assign job.tstamp     = in_time_now;
  assign job.first_addr = (pos_r == '0) ? in_frame_address : first_r;
  assign job.shorts     = short_sum;
  assign job.normals    = norm_sum;

  // snapshot state
  always_comb begin
    prev_nxt  = prev_r;
    first_nxt = first_r;
    pos_nxt   = pos_r;
    short_nxt = short_r;
    norm_nxt  = norm_r;
    if (accept) begin
      if (in_last_frame) begin
        prev_nxt  = '0;
        first_nxt = '0;
        pos_nxt   = '0;
        short_nxt = '0;
        norm_nxt  = '0;
      end else if (in_window) begin
        if (pos_r == '0) first_nxt = in_frame_address;
        prev_nxt  = in_frame_address;
        pos_nxt   = pos_r + 1'b1;
        short_nxt = short_sum;
        norm_nxt  = norm_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      first_r <= '0;
      pos_r   <= '0;
      short_r <= '0;
      norm_r  <= '0;
    end else begin
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      pos_r   <= pos_nxt;
      short_r <= short_nxt;
      norm_r  <= norm_nxt;
    end
  end

endmodule

// File: hw/rtl/sgr_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry FIFO between the front end and the table back end.
// ----------------------------------------------------------------------------
module sgr_queue import sgr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic not_empty,
  output logic full
);

  job_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign dout      = mem_r[rp_r];
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;

  // pointers and fill
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// File: hw/rtl/sgr_back.sv
// ----------------------------------------------------------------------------
// Table back end
// Set lookup with LRU, saturating totals, serial confidence divide, alert out.
// ----------------------------------------------------------------------------
module sgr_back import sgr_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int TABLE_WAYS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              clearing,
  input  logic [CONF_W-1:0] threshold,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PID_W-1:0]  out_alert_process,
  output logic [CONF_W-1:0] out_alert_confidence,
  output logic [TOT_W-1:0]  out_alert_gadget_total,
  output logic [TIME_W-1:0] out_alert_time,
  output logic [ADDR_W-1:0] out_alert_address
);

  localparam int SET_COUNT = TABLE_ENTRIES / TABLE_WAYS;
  localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W     = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int NUM_W     = TOT_W + CONF_W;

  // pid / SET_COUNT by reciprocal multiply, exact for every PID_W-bit pid
  localparam int SET_L  = $clog2(SET_COUNT);
  localparam int DIV_SH = PID_W + SET_L;
  localparam int RCP_W  = PID_W + 1;
  localparam int PROD_W = DIV_SH + PID_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT));

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_LOOK  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WR    = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SET_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                    mod_cnt_r, mod_cnt_nxt;
  logic [SET_W-1:0]        set_r, set_nxt;
  logic [2:0]              div_cnt_r, div_cnt_nxt;
  job_t                    job_r;
  way_t [TABLE_WAYS-1:0]   mem_q, row_r, row_look, row_wr;
  way_t [TABLE_WAYS-1:0]   tbl_mem [SET_COUNT];
  logic [WAY_W-1:0]        way_r, way_look;
  logic [TOT_W:0]          tot_r, tot_look;
  logic [NUM_W-1:0]        num_r, num_nxt, dsh;
  logic [CONF_W-1:0]       q_r, q_nxt;
  logic [PROD_W-1:0]       prod;
  logic [PID_W-1:0]        quo_r, rem;
  logic                    out_free, fire, alert, mem_we;
  logic [SET_W-1:0]        mem_wa;
  way_t [TABLE_WAYS-1:0]   mem_wd;

  logic                    out_valid_r;
  logic [PID_W-1:0]        o_pid_r;
  logic [CONF_W-1:0]       o_conf_r;
  logic [TOT_W-1:0]        o_tot_r;
  logic [TIME_W-1:0]       o_time_r;
  logic [ADDR_W-1:0]       o_addr_r;

  assign clearing = state_r == S_CLEAR;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // set index: quotient registered first, then the remainder taken from it
  assign prod = PROD_W'(job_r.pid) * PROD_W'(RCP);
  assign rem  = job_r.pid - quo_r * PID_W'(SET_COUNT);

  // way lookup, LRU update and saturating totals
  always_comb begin
    logic             hit_f, free_f;
    logic [WAY_W-1:0] hit_w, free_w, old_w, sel_w;
    logic [4:0]       old_rank;
    logic [TOT_W:0]   s_sum, n_sum;
    row_look = mem_q;
    hit_f    = 1'b0;
    free_f   = 1'b0;
    hit_w    = '0;
    free_w   = '0;
    old_w    = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (mem_q[w].valid) begin
        if (!hit_f && mem_q[w].tag == job_r.pid) begin
          hit_f = 1'b1;
          hit_w = WAY_W'(w);
        end
        if (mem_q[w].age > mem_q[old_w].age || !mem_q[old_w].valid) old_w = WAY_W'(w);
      end else if (!free_f) begin
        free_f = 1'b1;
        free_w = WAY_W'(w);
      end
    end
    if (hit_f) begin
      sel_w    = hit_w;
      old_rank = 5'(mem_q[hit_w].age);
    end else begin
      sel_w    = free_f ? free_w : old_w;
      old_rank = free_f ? 5'(TABLE_WAYS) : 5'(mem_q[old_w].age);
      row_look[sel_w] = '0;
      row_look[sel_w].valid = 1'b1;
      row_look[sel_w].tag   = job_r.pid;
    end
    for (int v = 0; v < TABLE_WAYS; v++) begin
      if (WAY_W'(v) != sel_w && mem_q[v].valid && 5'(mem_q[v].age) < old_rank)
        row_look[v].age = mem_q[v].age + 1'b1;
    end
    row_look[sel_w].age = '0;
    s_sum = (TOT_W+1)'(row_look[sel_w].s_tot) + (TOT_W+1)'(job_r.shorts);
    n_sum = (TOT_W+1)'(row_look[sel_w].n_tot) + (TOT_W+1)'(job_r.normals);
    row_look[sel_w].s_tot     = s_sum[TOT_W] ? TOT_MAX : s_sum[TOT_W-1:0];
    row_look[sel_w].n_tot     = n_sum[TOT_W] ? TOT_MAX : n_sum[TOT_W-1:0];
    row_look[sel_w].last_time = job_r.tstamp;
    tot_look = (TOT_W+1)'(row_look[sel_w].s_tot) + (TOT_W+1)'(row_look[sel_w].n_tot);
    way_look = sel_w;
  end

  // confidence divide, one quotient bit a cycle
  assign dsh = NUM_W'(tot_r) << div_cnt_r;

  always_comb begin
    num_nxt = num_r;
    q_nxt   = q_r;
    if (state_r == S_MUL) begin
      num_nxt = (NUM_W'(row_r[way_r].s_tot) << 6) + (NUM_W'(row_r[way_r].s_tot) << 5)
              + (NUM_W'(row_r[way_r].s_tot) << 2);
      q_nxt   = '0;
    end else if (state_r == S_DIV && num_r >= dsh) begin
      num_nxt          = num_r - dsh;
      q_nxt[div_cnt_r] = 1'b1;
    end
  end

  // write-back and alert decision
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == S_WR) && out_free;
  assign alert    = (q_r >= threshold) && !row_r[way_r].alerted;

  always_comb begin
    row_wr = row_r;
    row_wr[way_r].conf = q_r;
    if (alert) row_wr[way_r].alerted = 1'b1;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mod_cnt_nxt = mod_cnt_r;
    set_nxt     = set_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SET_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          state_nxt   = S_MOD;
          set_nxt     = '0;
          mod_cnt_nxt = 1'b0;
        end
      end
      S_MOD: begin
        mod_cnt_nxt = 1'b1;
        if (mod_cnt_r) begin
          set_nxt   = rem[SET_W-1:0];
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_MUL;
      S_MUL: begin
        state_nxt   = S_DIV;
        div_cnt_nxt = 3'(CONF_W - 1);
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mod_cnt_r <= mod_cnt_nxt;
    set_r     <= set_nxt;
    div_cnt_r <= div_cnt_nxt;
    num_r     <= num_nxt;
    q_r       <= q_nxt;
    if (q_pop) job_r <= q_job;
    if (state_r == S_MOD && !mod_cnt_r) quo_r <= prod[DIV_SH +: PID_W];
    if (state_r == S_LOOK) begin
      row_r <= row_look;
      way_r <= way_look;
      tot_r <= tot_look;
    end
  end

  // table memory, one row per set
  assign mem_we = clearing || fire;
  assign mem_wa = clearing ? clr_cnt_r : set_r;
  assign mem_wd = clearing ? '0 : row_wr;

  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[mem_wa] <= mem_wd;
    if (state_r == S_RD) mem_q <= tbl_mem[set_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && alert) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && alert) begin
      o_pid_r  <= job_r.pid;
      o_conf_r <= q_r;
      o_tot_r  <= row_r[way_r].s_tot;
      o_time_r <= job_r.tstamp;
      o_addr_r <= job_r.first_addr;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_alert_process      = o_pid_r;
  assign out_alert_confidence   = o_conf_r;
  assign out_alert_gadget_total = o_tot_r;
  assign out_alert_time         = o_time_r;
  assign out_alert_address      = o_addr_r;

endmodule

// File: hw/rtl/stack_gadget_rop_scorer.sv
// ----------------------------------------------------------------------------
// Stack gadget ROP scorer
// Frames are taken one a cycle while in_stall is low; a snapshot with short
// pairs goes, after any queue wait, through the table back end's set index,
// row read, lookup and serial confidence divide; the alert is registered at write-back.
// Reset: a clearing pass over every set empties the table,
// input stalls meanwhile; configuration returns to 70 / 5 / 4096.
// ----------------------------------------------------------------------------
module stack_gadget_rop_scorer import sgr_pkg::*; #(
  parameter int MAX_FRAMES    = 16,
  parameter int TABLE_ENTRIES = 4096,
  parameter int TABLE_WAYS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PID_W-1:0]  in_process_id,
  input  logic [ADDR_W-1:0] in_frame_address,
  input  logic              in_last_frame,
  input  logic [TIME_W-1:0] in_time_now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PID_W-1:0]  out_alert_process,
  output logic [CONF_W-1:0] out_alert_confidence,
  output logic [TOT_W-1:0]  out_alert_gadget_total,
  output logic [TIME_W-1:0] out_alert_time,
  output logic [ADDR_W-1:0] out_alert_address,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  logic [CONF_W-1:0] thr_r;
  logic [LEN_W-1:0]  min_len_r, max_delta_r;
  logic              push, pop, q_ne, q_full, clearing;
  job_t              job_in, job_out;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      min_len_r   <= MIN_LEN_RST;
      max_delta_r <= MAX_DELTA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r       <= cfg_data[CONF_W-1:0];
        REG_MIN_LEN:   min_len_r   <= cfg_data;
        REG_MAX_DELTA: max_delta_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sgr_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_process_id, .in_frame_address,
    .in_last_frame, .in_time_now,
    .min_len   (min_len_r),
    .max_delta (max_delta_r),
    .hold      (q_full || clearing),
    .push      (push),
    .job       (job_in)
  );

  sgr_queue u_queue (
    .clk, .rst_n,
    .push      (push),
    .din       (job_in),
    .pop       (pop),
    .dout      (job_out),
    .not_empty (q_ne),
    .full      (q_full)
  );

  sgr_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .TABLE_WAYS(TABLE_WAYS)) u_back (
    .clk, .rst_n,
    .q_valid   (q_ne),
    .q_job     (job_out),
    .q_pop     (pop),
    .clearing  (clearing),
    .threshold (thr_r),
    .out_valid, .out_stall, .out_alert_process, .out_alert_confidence,
    .out_alert_gadget_total, .out_alert_time, .out_alert_address
  );

endmodule

// File: hw/rtl/sgr_checker.sv
// ----------------------------------------------------------------------------
// Stack gadget ROP scorer port checker
// Port-level properties, bound onto the top level.
// ----------------------------------------------------------------------------
`include "stack_gadget_rop_scorer_assert.svh"

module sgr_checker import sgr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CONF_W-1:0] out_alert_confidence
);

  // a stalled result stays offered
  `SGR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")

  // confidence is a percentage
  `SGR_ASSERT(a_conf_range, clk, rst_n, out_valid |-> out_alert_confidence <= 7'd100, "bad conf")

  // table clearing blocks input right after reset
  `SGR_ASSERT_ALWAYS(a_rst_stall, clk, !rst_n |=> in_stall, "input open during clear")

  // no result straight out of reset
  `SGR_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result after reset")

endmodule

bind stack_gadget_rop_scorer sgr_checker u_sgr_checker (.*);
